>>> sv/i2c_slave_register_exchange_macros.svh
// Assertion macros shared by the checker of the register exchange block.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef I2C_SLAVE_REGISTER_EXCHANGE_MACROS_SVH
`define I2C_SLAVE_REGISTER_EXCHANGE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

>>> sv/ise_pkg.sv
// Package for the register exchange block: register indexes, sequencer steps.
// Depends on nothing.
`timescale 1ns / 1ps

package ise_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned AddrW   = 7;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StepW   = 7;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCL_HIGH  = 2'd0,
    CFG_SCL_LOW   = 2'd1,
    CFG_SDA_ONE   = 2'd2,
    CFG_OWN_ADDR  = 2'd3
  } cfg_index_e;

  typedef logic [StepW-1:0] step_t;

  localparam logic [SampleW-1:0] SclHighReset = 12'd4000;
  localparam logic [SampleW-1:0] SclLowReset  = 12'd2300;
  localparam logic [SampleW-1:0] SdaOneReset  = 12'd4000;
  localparam logic [AddrW-1:0]   OwnAddrReset = 7'd2;

  localparam step_t StepHunt      = 7'd0;
  localparam step_t StepAddrCheck = 7'd16;
  localparam step_t StepAckAddr   = 7'd17;
  localparam step_t StepRelAddr   = 7'd18;
  localparam step_t StepDataFirst = 7'd19;
  localparam step_t StepDataLast  = 7'd33;
  localparam step_t StepAckData   = 7'd34;
  localparam step_t StepRelData   = 7'd36;
  localparam step_t StepAddr2First = 7'd1;
  localparam step_t StepAddr2Last = 7'd13;
  localparam step_t StepSkipFirst = 7'd41;
  localparam step_t StepSkipLast  = 7'd55;
  localparam step_t StepAckAddr2  = 7'd56;
  localparam step_t StepRelAddr2  = 7'd58;
  localparam step_t StepReplyLoad = 7'd59;
  localparam step_t StepReplyFirst = 7'd61;
  localparam step_t StepReplyLast = 7'd73;
  localparam step_t StepAckReply  = 7'd74;
  localparam step_t StepRelReply  = 7'd76;
  localparam step_t StepLast      = 7'd77;
  localparam step_t StepMismatch  = 7'd79;

endpackage

>>> sv/i2c_slave_register_exchange.sv
// Top level of the register exchange block: sample-driven I2C slave sequencer.
// Depends on ise_pkg.
`timescale 1ns / 1ps
//
// Usage: each input request carries one converter sample of SCL and of SDA
// plus the reply byte; it is accepted when in_valid_i is high and
// in_stall_o is low. Every request yields exactly one result request with
// the SDA drive enable and level, a done pulse and the last received byte,
// accepted when out_valid_o is high and out_stall_i is low.
// The sequencer state and the result register load at the edge that accepts
// the input. The block takes one request per cycle while in_stall_o is low;
// the step, shift and drive registers each feed back into their own next state.
// When the receiver stalls, the result holds and in_stall_o rises only while
// the held result is not being taken.
// Configuration writes use cfg_valid_i/cfg_ready_o with a register index
// and data; ready is always high. Reset restores the register defaults,
// returns the sequencer to the address hunt and clears all byte holds.

module i2c_slave_register_exchange
  import ise_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SampleW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [SampleW-1:0] scl_sample_i,
  input  logic [SampleW-1:0] sda_sample_i,
  input  logic [ByteW-1:0]   reply_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               sda_drive_enable_o,
  output logic               sda_drive_value_o,
  output logic               transaction_done_o,
  output logic [ByteW-1:0]   received_byte_o
);

  logic [SampleW-1:0] scl_high_q, scl_low_q, sda_one_q;
  logic [AddrW-1:0]   own_addr_q;
  step_t              step_q, step_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic [ByteW-1:0]   data_q, data_d;
  logic [ByteW-1:0]   reply_q, reply_d;
  logic               drv_en_q, drv_en_d;
  logic               drv_val_q, drv_val_d;
  logic               done_q, done_d;
  logic               out_valid_q;
  logic               in_accept;
  logic               scl_high, scl_low, sda_bit;
  logic               shift_in_step, reply_shift_step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_high_q <= SclHighReset;
      scl_low_q  <= SclLowReset;
      sda_one_q  <= SdaOneReset;
      own_addr_q <= OwnAddrReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_SCL_HIGH: scl_high_q <= cfg_data_i;
        CFG_SCL_LOW:  scl_low_q  <= cfg_data_i;
        CFG_SDA_ONE:  sda_one_q  <= cfg_data_i;
        CFG_OWN_ADDR: own_addr_q <= cfg_data_i[AddrW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign scl_high = scl_sample_i >= scl_high_q;
  assign scl_low  = scl_sample_i <= scl_low_q;
  assign sda_bit  = sda_sample_i > sda_one_q;

  assign shift_in_step =
    (step_q >= StepAddr2First && step_q <= StepAddr2Last) ||
    (step_q >= StepDataFirst  && step_q <= StepDataLast)  ||
    (step_q >= StepSkipFirst  && step_q <= StepSkipLast);
  assign reply_shift_step = step_q >= StepReplyFirst && step_q <= StepReplyLast;

  always_comb begin
    step_d    = step_q;
    shift_d   = shift_q;
    data_d    = data_q;
    reply_d   = reply_q;
    drv_en_d  = drv_en_q;
    drv_val_d = drv_val_q;
    done_d    = done_q;
    if (in_accept) begin
      done_d = 1'b0;
      priority if (step_q > StepLast && step_q != StepMismatch) begin
        step_d = StepHunt;
      end else if (step_q[0]) begin
        if (scl_high) begin
          if (step_q == StepMismatch) begin
            step_d = StepHunt;
          end else begin
            step_d = (step_q == StepLast) ? StepHunt : step_q + step_t'(1);
            priority if (shift_in_step) begin
              shift_d = {shift_q[ByteW-2:0], sda_bit};
            end else if (step_q == StepReplyLoad) begin
              drv_en_d  = 1'b1;
              drv_val_d = reply_q[ByteW-1];
              shift_d   = {reply_q[ByteW-2:0], 1'b0};
            end else if (reply_shift_step) begin
              drv_val_d = shift_q[ByteW-1];
              shift_d   = {shift_q[ByteW-2:0], 1'b0};
            end else if (step_q == StepLast) begin
              done_d = 1'b1;
            end else begin
              shift_d = shift_q;
            end
          end
        end
      end else if (scl_low) begin
        step_d = step_q + step_t'(1);
        unique case (step_q)
          StepAddrCheck: begin
            if (shift_q[AddrW-1:0] == own_addr_q) begin
              reply_d   = reply_byte_i;
              drv_en_d  = 1'b1;
              drv_val_d = 1'b0;
              step_d    = StepAckAddr;
            end else begin
              step_d = StepMismatch;
            end
          end
          StepRelAddr, StepRelData, StepRelAddr2, StepRelReply: drv_en_d = 1'b0;
          StepAckData: begin
            data_d    = shift_q;
            drv_en_d  = 1'b1;
            drv_val_d = 1'b0;
          end
          StepAckAddr2: begin
            drv_en_d  = 1'b1;
            drv_val_d = 1'b0;
          end
          StepAckReply: drv_val_d = 1'b0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StepHunt;
      shift_q     <= '0;
      data_q      <= '0;
      reply_q     <= '0;
      drv_en_q    <= 1'b0;
      drv_val_q   <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q    <= step_d;
      shift_q   <= shift_d;
      data_q    <= data_d;
      reply_q   <= reply_d;
      drv_en_q  <= drv_en_d;
      drv_val_q <= drv_val_d;
      done_q    <= done_d;
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign sda_drive_enable_o = drv_en_q;
  assign sda_drive_value_o  = drv_val_q;
  assign transaction_done_o = done_q;
  assign received_byte_o    = data_q;

endmodule

>>> sv/ise_checker.sv
// Port-level checker for the register exchange block, bound to its top level.
// Depends on ise_pkg and i2c_slave_register_exchange_macros.svh.
`timescale 1ns / 1ps
`include "i2c_slave_register_exchange_macros.svh"

module ise_checker
  import ise_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             sda_drive_enable_o,
  input logic             sda_drive_value_o,
  input logic             transaction_done_o,
  input logic [ByteW-1:0] received_byte_o
);

  `ASSERT_IMPL(a_stall_only_when_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `ASSERT_IMPL(a_done_released, clk_i, rst_ni, out_valid_o && transaction_done_o, !sda_drive_enable_o)
  `ASSERT_IMPL(a_done_level_low, clk_i, rst_ni, out_valid_o && transaction_done_o, !sda_drive_value_o)
  `ASSERT_NEXT(a_result_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(received_byte_o) && $stable(transaction_done_o))

endmodule

bind i2c_slave_register_exchange ise_checker u_ise_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .sda_drive_enable_o (sda_drive_enable_o),
  .sda_drive_value_o  (sda_drive_value_o),
  .transaction_done_o (transaction_done_o),
  .received_byte_o    (received_byte_o)
);

>>> tb/testbench.sv
// Self-checking bench for i2c_slave_register_exchange: SCL/SDA sample streams shaped as
// I2C exchanges, checked request by request against a cycle-free sequencer predictor.
// Depends on ise_pkg and the block's top level only.
`timescale 1ns / 1ps

module testbench;
  import ise_pkg::*;

  localparam int CycleLimit     = 500000;
  localparam int EventsPerPhase = 150;
  localparam int HoldoffCycles  = 80;
  localparam int NumPhases      = 6;
  localparam int NumRows        = 22;

  typedef struct packed {
    logic             drive_en;
    logic             drive_val;
    logic             done;
    logic [ByteW-1:0] rx_byte;
  } line_report_t;

  typedef struct packed {
    logic [SampleW-1:0] scl;
    logic [SampleW-1:0] sda;
    logic [ByteW-1:0]   reply;
    logic               typed;
    line_report_t       want;
  } directed_row_t;

  localparam line_report_t QuietLine = '0;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_valid_i  = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i  = CFG_SCL_HIGH;
  logic [SampleW-1:0] cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [SampleW-1:0] scl_sample_i = '0;
  logic [SampleW-1:0] sda_sample_i = '0;
  logic [ByteW-1:0]   reply_byte_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic               sda_drive_enable_o;
  logic               sda_drive_value_o;
  logic               transaction_done_o;
  logic [ByteW-1:0]   received_byte_o;

  // settings as last written
  logic [SampleW-1:0] scl_high_lvl = SclHighReset;
  logic [SampleW-1:0] scl_low_lvl  = SclLowReset;
  logic [SampleW-1:0] sda_one_lvl  = SdaOneReset;
  logic [AddrW-1:0]   own_addr     = OwnAddrReset;

  // sequencer state as predicted
  step_t            seq_step    = StepHunt;
  logic [ByteW-1:0] shift_bits  = '0;
  logic [ByteW-1:0] rx_hold     = '0;
  logic [ByteW-1:0] reply_latch = '0;
  logic             drv_en      = 1'b0;
  logic             drv_val     = 1'b0;

  line_report_t due_reports[$];
  directed_row_t directed_rows [NumRows];

  int mismatches     = 0;
  int cycle_count    = 0;
  int events_done    = 0;
  int clock_budget   = 0;
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int holdoff_asked  = 0;
  int holdoff_served = 0;
  int holdoff_left   = 0;

  i2c_slave_register_exchange DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .scl_sample_i       (scl_sample_i),
    .sda_sample_i       (sda_sample_i),
    .reply_byte_i       (reply_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .sda_drive_enable_o (sda_drive_enable_o),
    .sda_drive_value_o  (sda_drive_value_o),
    .transaction_done_o (transaction_done_o),
    .received_byte_o    (received_byte_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic bit in_span(step_t s, step_t lo, step_t hi);
    return s >= lo && s <= hi;
  endfunction

  task automatic step_sequencer(input logic [SampleW-1:0] scl, input logic [SampleW-1:0] sda,
                                input logic [ByteW-1:0] reply, output line_report_t rep);
    logic  bit_in;
    logic  done;
    step_t nxt;
    bit_in = sda > sda_one_lvl;
    done   = 1'b0;
    if (seq_step > StepLast && seq_step != StepMismatch) begin
      seq_step = StepHunt;
    end else if (seq_step[0]) begin
      if (scl >= scl_high_lvl) begin
        if (seq_step == StepMismatch) begin
          seq_step = StepHunt;
        end else begin
          if (in_span(seq_step, StepAddr2First, StepAddr2Last) ||
              in_span(seq_step, StepDataFirst, StepDataLast) ||
              in_span(seq_step, StepSkipFirst, StepSkipLast)) begin
            shift_bits = {shift_bits[ByteW-2:0], bit_in};
          end else if (seq_step == StepReplyLoad) begin
            drv_en     = 1'b1;
            drv_val    = reply_latch[ByteW-1];
            shift_bits = {reply_latch[ByteW-2:0], 1'b0};
          end else if (in_span(seq_step, StepReplyFirst, StepReplyLast)) begin
            drv_val    = shift_bits[ByteW-1];
            shift_bits = {shift_bits[ByteW-2:0], 1'b0};
          end
          done     = seq_step == StepLast;
          seq_step = done ? StepHunt : seq_step + step_t'(1);
        end
      end
    end else if (scl <= scl_low_lvl) begin
      nxt = seq_step + step_t'(1);
      case (seq_step)
        StepAddrCheck: begin
          if (shift_bits[AddrW-1:0] == own_addr) begin
            reply_latch = reply;
            drv_en      = 1'b1;
            drv_val     = 1'b0;
            nxt         = StepAckAddr;
          end else begin
            nxt = StepMismatch;
          end
        end
        StepRelAddr, StepRelData, StepRelAddr2, StepRelReply: begin
          drv_en = 1'b0;
        end
        StepAckData: begin
          rx_hold = shift_bits;
          drv_en  = 1'b1;
          drv_val = 1'b0;
        end
        StepAckAddr2: begin
          drv_en  = 1'b1;
          drv_val = 1'b0;
        end
        StepAckReply: begin
          drv_val = 1'b0;
        end
        default: begin
        end
      endcase
      seq_step = nxt;
    end
    rep = '{drive_en: drv_en, drive_val: drv_val, done: done, rx_byte: rx_hold};
  endtask

  task automatic put_sample(input logic [SampleW-1:0] scl, input logic [SampleW-1:0] sda,
                            input logic [ByteW-1:0] reply, input logic typed,
                            input line_report_t typed_rep);
    line_report_t rep;
    step_t        was;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    scl_sample_i <= scl;
    sda_sample_i <= sda;
    reply_byte_i <= reply;
    do @(posedge clk_i); while (in_stall_o);
    was = seq_step;
    step_sequencer(scl, sda, reply, rep);
    due_reports.push_back(typed ? typed_rep : rep);
    if (seq_step != was) events_done++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [SampleW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SCL_HIGH: scl_high_lvl = data;
      CFG_SCL_LOW:  scl_low_lvl  = data;
      CFG_SDA_ONE:  sda_one_lvl  = data;
      CFG_OWN_ADDR: own_addr     = data[AddrW-1:0];
      default: begin
      end
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [SampleW-1:0] high, input logic [SampleW-1:0] low,
                                input logic [SampleW-1:0] one, input logic [SampleW-1:0] addr);
    write_reg(CFG_SCL_HIGH, high);
    write_reg(CFG_SCL_LOW, low);
    write_reg(CFG_SDA_ONE, one);
    write_reg(CFG_OWN_ADDR, addr);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [SampleW-1:0] scl_level(bit high);
    return high ? SampleW'($urandom_range(4095, scl_high_lvl))
                : SampleW'($urandom_range(scl_low_lvl, 0));
  endfunction

  function automatic logic [SampleW-1:0] sda_level(bit one);
    if (!one) return SampleW'($urandom_range(sda_one_lvl, 0));
    if (sda_one_lvl == '1) return '1;
    return SampleW'($urandom_range(4095, int'(sda_one_lvl) + 1));
  endfunction

  task automatic scl_phase(input bit high, input bit one, input logic [ByteW-1:0] reply);
    int reps;
    if (int'(scl_low_lvl) + 1 < int'(scl_high_lvl) && $urandom_range(99) < 20)
      put_sample(SampleW'($urandom_range(int'(scl_high_lvl) - 1, int'(scl_low_lvl) + 1)),
                 SampleW'($urandom_range(4095, 0)), reply, 1'b0, QuietLine);
    reps = $urandom_range(3, 1);
    repeat (reps) put_sample(scl_level(high), sda_level(one), reply, 1'b0, QuietLine);
  endtask

  task automatic clock_bit(input bit one, input logic [ByteW-1:0] reply);
    if (clock_budget == 0) return;
    clock_budget--;
    scl_phase(1'b1, one, reply);
    scl_phase(1'b0, 1'($urandom_range(1, 0)), reply);
  endtask

  task automatic send_bits(input logic [ByteW-1:0] v, input int n, input logic [ByteW-1:0] reply);
    for (int i = n - 1; i >= 0; i--) clock_bit(v[i], reply);
  endtask

  task automatic exchange(input bit broken);
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] reply;
    addr  = ($urandom_range(99) < 80) ? own_addr : AddrW'($urandom_range(127, 0));
    reply = ByteW'($urandom_range(255, 0));
    clock_budget = broken ? $urandom_range(38, 1) : 1000;
    scl_phase(1'b0, 1'($urandom_range(1, 0)), reply);
    send_bits({1'b0, addr}, AddrW, reply);
    send_bits(ByteW'($urandom_range(3, 0)), 2, reply);
    if (seq_step != StepDataFirst) return;
    send_bits(ByteW'($urandom_range(255, 0)), ByteW + 3, reply);
    send_bits(ByteW'($urandom_range(255, 0)), ByteW + 1, reply);
    send_bits(ByteW'($urandom_range(255, 0)), ByteW, reply);
    send_bits(ByteW'($urandom_range(3, 0)), 2, reply);
  endtask

  task automatic resync();
    clock_budget = 1000;
    while (seq_step > StepHunt + step_t'(1))
      clock_bit(1'($urandom_range(1, 0)), ByteW'($urandom_range(255, 0)));
  endtask

  always @(negedge clk_i) begin
    if (holdoff_left > 0) begin
      out_stall_i  <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_served != holdoff_asked) begin
      out_stall_i    <= 1'b1;
      holdoff_left   <= HoldoffCycles;
      holdoff_served <= holdoff_served + 1;
    end else begin
      out_stall_i <= $urandom_range(99) < stall_pct;
    end
  end

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    line_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time,
                 {sda_drive_enable_o, sda_drive_value_o, transaction_done_o, received_byte_o});
        mismatches++;
      end else begin
        want = due_reports.pop_front();
        check_field("sda_drive_enable", want.drive_en, sda_drive_enable_o);
        check_field("sda_drive_value", want.drive_val, sda_drive_value_o);
        check_field("transaction_done", want.done, transaction_done_o);
        check_field("received_byte", want.rx_byte, received_byte_o);
      end
    end
  end

  initial begin
    logic [SampleW-1:0] high;
    int                 pick;
    // hunt thresholds at their edges, then a wrong address and its released ACK clock
    directed_rows = '{
      '{12'd4095, 12'd4095, 8'd255, 1'b1, QuietLine},
      '{12'd2301, 12'd0,    8'd0,   1'b1, QuietLine},
      '{12'd2300, 12'd4095, 8'd255, 1'b1, QuietLine},
      '{12'd3999, 12'd4095, 8'd0,   1'b1, QuietLine},
      '{12'd4000, 12'd4000, 8'd0,   1'b1, QuietLine},
      '{12'd0,    12'd0,    8'd0,   1'b1, QuietLine},
      '{12'd4095, 12'd0,    8'd0,   1'b0, QuietLine},
      '{12'd1000, 12'd4095, 8'd0,   1'b0, QuietLine},
      '{12'd4095, 12'd0,    8'd0,   1'b0, QuietLine},
      '{12'd0,    12'd0,    8'd0,   1'b0, QuietLine},
      '{12'd4095, 12'd0,    8'd0,   1'b0, QuietLine},
      '{12'd0,    12'd0,    8'd0,   1'b0, QuietLine},
      '{12'd4095, 12'd0,    8'd0,   1'b0, QuietLine},
      '{12'd0,    12'd0,    8'd0,   1'b0, QuietLine},
      '{12'd4095, 12'd4001, 8'd0,   1'b0, QuietLine},
      '{12'd0,    12'd0,    8'd0,   1'b0, QuietLine},
      '{12'd4095, 12'd4095, 8'd0,   1'b0, QuietLine},
      '{12'd0,    12'd0,    8'd0,   1'b0, QuietLine},
      '{12'd4095, 12'd0,    8'd0,   1'b0, QuietLine},
      '{12'd2300, 12'd4095, 8'hA5,  1'b1, QuietLine},
      '{12'd4000, 12'd0,    8'd0,   1'b1, QuietLine},
      '{12'd0,    12'd0,    8'd0,   1'b0, QuietLine}
    };
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        1: begin
          high = SampleW'($urandom_range(4095, 2048));
          apply_settings(high, SampleW'($urandom_range(int'(high) - 1, 0)),
                         SampleW'($urandom_range(4095, 0)), SampleW'($urandom_range(4095, 0)));
          send_idle_pct = 70;
          stall_pct     = 0;
        end
        2: begin
          apply_settings('1, '0, '0, '1);
          send_idle_pct = 0;
          stall_pct     = 70;
        end
        3: begin
          apply_settings('0, '1, '1, '0);
          send_idle_pct = 37;
          stall_pct     = 37;
        end
        4: begin
          apply_settings(SampleW'($urandom_range(4095, 0)), SampleW'($urandom_range(4095, 0)),
                         SampleW'($urandom_range(4095, 0)), SampleW'($urandom_range(4095, 0)));
          send_idle_pct = 0;
          stall_pct     = 0;
          holdoff_asked++;
        end
        5: begin
          apply_settings(SclHighReset, SclLowReset, SdaOneReset, SampleW'(OwnAddrReset));
          send_idle_pct = 37;
          stall_pct     = 37;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          for (int i = 0; i < NumRows; i++)
            put_sample(directed_rows[i].scl, directed_rows[i].sda, directed_rows[i].reply,
                       directed_rows[i].typed, directed_rows[i].want);
        end
      endcase
      events_done = 0;
      while (events_done < EventsPerPhase) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          exchange(1'b0);
        end else if (pick < 90) begin
          exchange(1'b1);
        end else begin
          repeat ($urandom_range(6, 1))
            put_sample(SampleW'($urandom_range(4095, 0)), SampleW'($urandom_range(4095, 0)),
                       ByteW'($urandom_range(255, 0)), 1'b0, QuietLine);
        end
        resync();
      end
      in_valid_i <= 1'b0;
      while (due_reports.size() != 0) @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
